FILE: hdl/sorted_beat_table_nearest_macros.svh
// Assertion macros for the beat table top level.
// No dependencies.
`ifndef SORTED_BEAT_TABLE_NEAREST_MACROS_SVH
`define SORTED_BEAT_TABLE_NEAREST_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define SBT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hdl/sbt_pkg.sv
// Package for the sorted beat table: widths, commands, back-end states.
// No dependencies.
`timescale 1ns / 1ps
package sbt_pkg;
  localparam int unsigned CapacityDef = 256;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SlotW  = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned TempoW = 36;
  localparam int unsigned ManW   = 20;
  localparam logic [TempoW-1:0] TempoNum = 36'd60000000000;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_NEAR  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  localparam logic CFG_MAN_TEMPO = 1'b0;
  localparam logic CFG_AUD_LEN   = 1'b1;

  typedef struct packed {
    cmd_e              cmd;
    logic [TimeW-1:0]  tm;
    logic [SlotW-1:0]  slot;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SCAN_W, ST_SHIFT, ST_SHIFT_W, ST_PUT, ST_RDX, ST_RDX_W,
    ST_ENDS, ST_ENDS_W, ST_ENDS_W2, ST_DIV1, ST_DIV2, ST_OUT
  } bk_state_e;
endpackage

FILE: hdl/sbt_queue.sv
// Front end: two-entry FIFO holding accepted command beats.
// Depends on sbt_pkg.
`timescale 1ns / 1ps
module sbt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sbt_pkg::item_t in_item_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output sbt_pkg::item_t q_item_o
);
  import sbt_pkg::*;
  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;
  assign q_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: hdl/sbt_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
module sbt_div #(
  parameter int unsigned W = 36
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0]  quo_q, den_q;
  logic [W:0]    rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial = {rem_q[W-1:0], quo_q[W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign quo_o = quo_q;
  assign done_o = busy_q && (cnt_q == CW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1; cnt_q <= CW'(W);
    end else if (busy_q) begin
      if (cnt_q == CW'(0)) busy_q <= 1'b0;
      else cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i; den_q <= den_i; rem_q <= '0;
    end else if (busy_q && cnt_q != CW'(0)) begin
      if (!diff[W]) begin
        rem_q <= diff;
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end
endmodule

FILE: hdl/sbt_back.sv
// Back end: beat memory, scan/shift sequencer, statistics divisions.
// Depends on sbt_pkg and sbt_div.
`timescale 1ns / 1ps
module sbt_back #(
  parameter int unsigned CAPACITY = sbt_pkg::CapacityDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_ready_o,
  input  sbt_pkg::item_t             q_item_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_index_i,
  input  logic [sbt_pkg::TimeW-1:0]  cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sbt_pkg::TimeW-1:0]  time_out_o,
  output logic [sbt_pkg::SlotW-1:0]  slot_out_o,
  output logic [sbt_pkg::CountW-1:0] entry_count_o,
  output logic [sbt_pkg::TimeW-1:0]  mean_gap_us_o,
  output logic [sbt_pkg::TempoW-1:0] tempo_mbpm_o,
  output logic [sbt_pkg::TimeW-1:0]  length_us_o,
  output logic                       add_dropped_o
);
  import sbt_pkg::*;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned NW = $clog2(CAPACITY + 1);

  logic [TimeW-1:0] mem [CAPACITY];
  logic [TimeW-1:0] rd_q;
  logic [AW-1:0]    raddr;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [TimeW-1:0] wdata;

  bk_state_e st_q, st_d;
  item_t     it_q;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic [NW-1:0]    pos_q, pos_d;
  logic [TimeW-1:0] prev_q, prev_d, first_q, first_d;
  logic [TimeW-1:0] tout_q, tout_d;
  logic [SlotW-1:0] sout_q, sout_d;
  logic             drop_q, drop_d;
  logic [ManW-1:0]  man_q;
  logic [TimeW-1:0] alen_q;
  logic [TimeW-1:0] last_q, last_d, gap_q, gap_d;
  logic             ov_q;
  logic [TimeW-1:0] o_time_q, o_gap_q, o_len_q;
  logic [SlotW-1:0] o_slot_q;
  logic [CountW-1:0] o_cnt_q;
  logic [TempoW-1:0] o_tempo_q;
  logic             o_drop_q;
  logic             div_start, div_done;
  logic [TempoW-1:0] div_num, div_den, div_quo;
  logic             man_clr;
  logic [TempoW-1:0] tempo_v;
  logic [TimeW-1:0]  len_v;

  sbt_div #(.W(TempoW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  assign q_ready_o = (st_q == ST_IDLE) && !ov_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; pos_d = pos_q; prev_d = prev_q; first_d = first_q;
    tout_d = tout_q; sout_d = sout_q; drop_d = drop_q; last_d = last_q; gap_d = gap_q;
    we = 1'b0; waddr = pos_q[AW-1:0]; wdata = it_q.tm; raddr = pos_q[AW-1:0];
    div_start = 1'b0; div_num = '0; div_den = '0; man_clr = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i && !ov_q) begin
          tout_d = '0; sout_d = '0; drop_d = 1'b0; pos_d = '0;
          case (q_item_i.cmd)
            CMD_ADD: begin
              if (cnt_q >= NW'(CAPACITY)) begin drop_d = 1'b1; st_d = ST_ENDS; end
              else st_d = ST_SCAN;
            end
            CMD_NEAR: begin
              // at or outside the table ends: first_q/last_q hold the end beats
              if (cnt_q == '0) st_d = ST_ENDS;
              else if (q_item_i.tm <= first_q) begin
                tout_d = first_q; st_d = ST_ENDS;
              end else if (q_item_i.tm >= last_q) begin
                tout_d = last_q; sout_d = SlotW'(cnt_q - NW'(1)); st_d = ST_ENDS;
              end else st_d = ST_SCAN;
            end
            CMD_READ: begin
              pos_d = NW'(q_item_i.slot);
              st_d = ({1'b0, q_item_i.slot} < 9'(cnt_q)) && (NW'(q_item_i.slot) < cnt_q)
                     ? ST_RDX : ST_ENDS;
            end
            default: begin cnt_d = '0; man_clr = 1'b1; st_d = ST_ENDS; end
          endcase
        end
      end
      // walk entries from pos_q upward, read then compare
      ST_SCAN: begin
        if (pos_q == cnt_q) begin
          if (it_q.cmd == CMD_ADD) st_d = ST_PUT;
          else begin
            tout_d = prev_q; sout_d = SlotW'(pos_q - NW'(1)); st_d = ST_ENDS;
          end
        end else st_d = ST_SCAN_W;
      end
      ST_SCAN_W: begin
        if (it_q.cmd == CMD_ADD) begin
          if (rd_q <= it_q.tm) begin pos_d = pos_q + NW'(1); st_d = ST_SCAN; end
          else begin pos_d = cnt_q; st_d = ST_SHIFT; end
          prev_d = it_q.tm - it_q.tm; // unused on add
          first_d = NW'(pos_q) == '0 ? first_q : first_q;
          last_d = last_q;
          if (!(rd_q <= it_q.tm)) gap_d = TimeW'(pos_q);
        end else begin
          if (rd_q >= it_q.tm) begin
            if (pos_q == '0 || (it_q.tm - prev_q) >= (rd_q - it_q.tm)) begin
              tout_d = rd_q; sout_d = SlotW'(pos_q);
            end else begin
              tout_d = prev_q; sout_d = SlotW'(pos_q - NW'(1));
            end
            st_d = ST_ENDS;
          end else begin
            prev_d = rd_q; pos_d = pos_q + NW'(1); st_d = ST_SCAN;
          end
        end
      end
      // move entries up by one, from the top down to the insert point (gap_q)
      ST_SHIFT: begin
        if (pos_q == NW'(gap_q)) st_d = ST_PUT;
        else begin raddr = AW'(pos_q - NW'(1)); st_d = ST_SHIFT_W; end
      end
      ST_SHIFT_W: begin
        we = 1'b1; waddr = pos_q[AW-1:0]; wdata = rd_q;
        pos_d = pos_q - NW'(1); st_d = ST_SHIFT;
      end
      ST_PUT: begin
        we = 1'b1; waddr = pos_q[AW-1:0]; wdata = it_q.tm;
        cnt_d = cnt_q + NW'(1); st_d = ST_ENDS;
      end
      ST_RDX: st_d = ST_RDX_W;
      ST_RDX_W: begin tout_d = rd_q; st_d = ST_ENDS; end
      ST_ENDS: begin raddr = '0; st_d = ST_ENDS_W; end
      ST_ENDS_W: begin
        first_d = rd_q; raddr = AW'(cnt_q - NW'(1)); st_d = ST_ENDS_W2;
      end
      ST_ENDS_W2: begin
        last_d = (cnt_q == '0) ? '0 : rd_q;
        if (cnt_q >= NW'(2)) begin
          div_start = 1'b1; div_num = TempoW'(rd_q - first_q);
          div_den = TempoW'(cnt_q - NW'(1)); st_d = ST_DIV1;
        end else begin gap_d = '0; st_d = ST_OUT; end
      end
      ST_DIV1: begin
        if (div_done) begin
          gap_d = div_quo[TimeW-1:0];
          if (div_quo != '0 && man_q == '0) begin
            div_start = 1'b1; div_num = TempoNum; div_den = div_quo; st_d = ST_DIV2;
          end else st_d = ST_OUT;
        end
      end
      ST_DIV2: if (div_done) st_d = ST_OUT;
      ST_OUT: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (man_q != '0) tempo_v = TempoW'(man_q);
    else if (gap_q != '0) tempo_v = div_quo;
    else tempo_v = '0;
    if (alen_q != '0) len_v = alen_q;
    else len_v = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; cnt_q <= '0; man_q <= '0; alen_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d;
      if (man_clr) begin
        man_q <= '0; alen_q <= '0;
      end else if (cfg_valid_i) begin
        if (cfg_index_i == CFG_MAN_TEMPO) man_q <= cfg_data_i[ManW-1:0];
        else alen_q <= cfg_data_i;
      end
      if (st_q == ST_OUT) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; prev_q <= prev_d; first_q <= first_d; tout_q <= tout_d;
    sout_q <= sout_d; drop_q <= drop_d; last_q <= last_d; gap_q <= gap_d;
    if (st_q == ST_IDLE && q_valid_i && !ov_q) it_q <= q_item_i;
    if (st_q == ST_OUT) begin
      o_time_q <= tout_q; o_slot_q <= sout_q; o_cnt_q <= CountW'(cnt_q);
      o_gap_q <= gap_q; o_tempo_q <= tempo_v; o_len_q <= len_v; o_drop_q <= drop_q;
    end
  end

  assign out_valid_o   = ov_q;
  assign time_out_o    = o_time_q;
  assign slot_out_o    = o_slot_q;
  assign entry_count_o = o_cnt_q;
  assign mean_gap_us_o = o_gap_q;
  assign tempo_mbpm_o  = o_tempo_q;
  assign length_us_o   = o_len_q;
  assign add_dropped_o = o_drop_q;
endmodule

FILE: hdl/sorted_beat_table_nearest.sv
// Sorted beat table with nearest-beat search: top level.
// Depends on sbt_pkg, sbt_queue, sbt_back and the macros header.
`timescale 1ns / 1ps
// An add, or a nearest search between the end beats, scans the table entry by
// entry; an add shifts up the entries above the insert point. With two or more
// entries, a division gives the mean gap and, unless a manual tempo is set or
// the gap is zero, a second the tempo. A two-beat queue accepts commands while
// the back end works; the result register is freed when its beat is taken.
`include "sorted_beat_table_nearest_macros.svh"
module sorted_beat_table_nearest #(
  parameter int unsigned CAPACITY = sbt_pkg::CapacityDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 command_i,
  input  logic [sbt_pkg::TimeW-1:0]  time_in_i,
  input  logic [sbt_pkg::SlotW-1:0]  slot_in_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [sbt_pkg::TimeW-1:0]  cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sbt_pkg::TimeW-1:0]  time_out_o,
  output logic [sbt_pkg::SlotW-1:0]  slot_out_o,
  output logic [sbt_pkg::CountW-1:0] entry_count_o,
  output logic [sbt_pkg::TimeW-1:0]  mean_gap_us_o,
  output logic [sbt_pkg::TempoW-1:0] tempo_mbpm_o,
  output logic [sbt_pkg::TimeW-1:0]  length_us_o,
  output logic                       add_dropped_o
);
  import sbt_pkg::*;
  item_t in_item, q_item;
  logic  q_valid, q_ready;

  assign in_item = '{cmd: cmd_e'(command_i), tm: time_in_i, slot: slot_in_i};
  assign cfg_ready_o = 1'b1;

  sbt_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  sbt_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i, .out_valid_o, .out_ready_i,
    .time_out_o, .slot_out_o, .entry_count_o, .mean_gap_us_o, .tempo_mbpm_o,
    .length_us_o, .add_dropped_o
  );

  `SBT_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(time_out_o))
  `SBT_ASSERT_IMP(a_cnt_max, out_valid_o, entry_count_o <= CountW'(CAPACITY))
  `SBT_ASSERT_IMP(a_drop_full, out_valid_o && add_dropped_o,
    entry_count_o == CountW'(CAPACITY))
endmodule
